// ===== rtl/interlocked_clean_cycle_sequencer_unit_defines.svh =====
// Assertion macros shared by the checker of the clean-cycle sequencer.
// Needs nothing else; each macro expects i_clk and i_rst_n in scope.
`ifndef INTERLOCKED_CLEAN_CYCLE_SEQUENCER_UNIT_DEFINES_SVH
`define INTERLOCKED_CLEAN_CYCLE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ICSU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icsu assertion failed");

// Next-cycle implication, checked outside reset.
`define ICSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icsu assertion failed");

`endif

// ===== rtl/icsu_pkg.sv =====
// Package of the clean-cycle sequencer: codes, payload and context types,
// and the event-handling functions. Depends on nothing.
`default_nettype none

package icsu_pkg;

    localparam int unsigned CfgWidth = 32;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_OCC   = 3'd1,
        ST_LEAVE = 3'd2,
        ST_DELAY = 3'd3,
        ST_CLEAN = 3'd4,
        ST_SAFE  = 3'd5,
        ST_FAULT = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_P2   = 2'd1,
        PH_P3   = 2'd2,
        PH_P1   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        FC_NONE    = 2'd0,
        FC_BIN     = 2'd1,
        FC_TIMEOUT = 2'd2,
        FC_PROTECT = 2'd3
    } t_fault;

    typedef enum logic [1:0] {
        MC_STOP = 2'd0,
        MC_FWD  = 2'd1,
        MC_REV  = 2'd2
    } t_motor;

    // The last code has no event behind it and only reports the status.
    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_SYNC     = 4'd1,
        OP_OCC_ON   = 4'd2,
        OP_OCC_OFF  = 4'd3,
        OP_START    = 4'd4,
        OP_POS1     = 4'd5,
        OP_POS2     = 4'd6,
        OP_POS3     = 4'd7,
        OP_PROT_ON  = 4'd8,
        OP_PROT_OFF = 4'd9,
        OP_STALL    = 4'd10,
        OP_BINFULL  = 4'd11,
        OP_RESET    = 4'd12,
        OP_DELAY_TO = 4'd13,
        OP_DONE     = 4'd14,
        OP_SPARE    = 4'd15
    } t_op;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LEAVE_CONFIRM = 3'd0;
    localparam logic [2:0] CFG_CLEAN_DELAY   = 3'd1;
    localparam logic [2:0] CFG_POS2_TIMEOUT  = 3'd2;
    localparam logic [2:0] CFG_POS3_TIMEOUT  = 3'd3;
    localparam logic [2:0] CFG_POS1_TIMEOUT  = 3'd4;
    localparam logic [2:0] CFG_TOTAL_TIMEOUT = 3'd5;

    typedef struct packed {
        logic [3:0] op;
        logic       occupied_level;
        logic       bin_full_level;
        logic       protect_level;
    } t_in_item;

    typedef struct packed {
        logic [2:0] cur_state;
        logic [1:0] cur_phase;
        logic [1:0] cur_fault;
        logic [1:0] motor_cmd;
        logic       fault_pulse;
        logic       bin_full_flag;
        logic       protect_flag;
    } t_out_item;

    typedef struct packed {
        logic [CfgWidth-1:0] leave_confirm_ticks;
        logic [CfgWidth-1:0] clean_delay_ticks;
        logic [CfgWidth-1:0] phase_pos2_timeout;
        logic [CfgWidth-1:0] phase_pos3_timeout;
        logic [CfgWidth-1:0] phase_pos1_timeout;
        logic [CfgWidth-1:0] total_clean_timeout;
    } t_cfg;

    // Control context of the sequencer. The pulse and the three counter
    // restart requests are per-item results and are cleared before each item.
    typedef struct packed {
        t_mode  mode;
        t_phase phase;
        t_fault fault;
        t_motor motor;
        logic   presence;
        logic   bin;
        logic   guard;
        logic   pulse;
        logic   clr_state;
        logic   clr_phase;
        logic   clr_cycle;
    } t_ctx;

    function automatic t_ctx start_leg(t_ctx c, t_phase p);
        t_ctx r;
        r = c;
        r.phase = p;
        r.clr_phase = 1'b1;
        case (p)
            PH_P2, PH_P1: r.motor = MC_FWD;
            PH_P3:        r.motor = MC_REV;
            default:      r.motor = MC_STOP;
        endcase
        return r;
    endfunction

    function automatic t_ctx go_state(t_ctx c, t_mode s);
        t_ctx r;
        r = c;
        if (c.mode != s) begin
            r.mode = s;
            r.clr_state = 1'b1;
            if (s == ST_CLEAN) begin
                r.fault = FC_NONE;
                r.clr_cycle = 1'b1;
                r = start_leg(r, PH_P2);
            end else begin
                r.phase = PH_NONE;
                r.motor = MC_STOP;
                if (s == ST_IDLE || s == ST_OCC || s == ST_LEAVE || s == ST_DELAY) begin
                    r.fault = FC_NONE;
                end
                if (s == ST_FAULT) begin
                    r.pulse = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_ctx raise_fault(t_ctx c, t_fault code);
        t_ctx r;
        r = c;
        r.fault = code;
        if (c.mode == ST_FAULT) begin
            r.motor = MC_STOP;
            r.pulse = 1'b1;
        end else begin
            r = go_state(r, ST_FAULT);
        end
        return r;
    endfunction

    function automatic t_mode idle_or_occ(t_ctx c);
        return c.presence ? ST_OCC : ST_IDLE;
    endfunction

    function automatic t_ctx recover_to(t_ctx c, t_mode s);
        t_ctx r;
        r = c;
        r.fault = FC_NONE;
        return go_state(r, s);
    endfunction

    function automatic t_ctx try_clean(t_ctx c);
        t_ctx r;
        if (c.presence) begin
            r = go_state(c, idle_or_occ(c));
        end else if (c.bin) begin
            r = raise_fault(c, FC_BIN);
        end else if (c.guard) begin
            r = go_state(c, idle_or_occ(c));
        end else begin
            r = go_state(c, ST_CLEAN);
        end
        return r;
    endfunction

    function automatic t_ctx reset_recover(t_ctx c);
        t_ctx r;
        if (c.guard || c.bin) begin
            r = c;
        end else begin
            r = recover_to(c, idle_or_occ(c));
        end
        return r;
    endfunction

    function automatic t_ctx protect_stop(t_ctx c);
        t_ctx r;
        r = c;
        r.fault = FC_PROTECT;
        return go_state(r, ST_SAFE);
    endfunction

    // Handles one event: flag updates and interlocks first, then the
    // state-specific reaction.
    function automatic t_ctx dispatch(t_ctx c, logic [3:0] ev);
        t_ctx r;
        logic done;
        r = c;
        done = 1'b0;
        case (ev)
            OP_OCC_ON:  r.presence = 1'b1;
            OP_OCC_OFF: r.presence = 1'b0;
            OP_BINFULL: r.bin = 1'b1;
            OP_PROT_ON: begin
                r.guard = 1'b1;
                if (r.mode == ST_CLEAN) begin
                    r = protect_stop(r);
                end
                done = 1'b1;
            end
            OP_PROT_OFF: r.guard = 1'b0;
            OP_STALL: begin
                r = raise_fault(r, FC_TIMEOUT);
                done = 1'b1;
            end
            default: ;
        endcase

        if (!done) begin
            case (r.mode)
                ST_IDLE, ST_OCC: begin
                    if (r.mode == ST_IDLE && ev == OP_OCC_ON) begin
                        r = go_state(r, ST_OCC);
                    end else if (r.mode == ST_OCC && ev == OP_OCC_OFF) begin
                        r = go_state(r, ST_LEAVE);
                    end else if (ev == OP_START) begin
                        r = try_clean(r);
                    end else if (ev == OP_BINFULL) begin
                        r = raise_fault(r, FC_BIN);
                    end
                end
                ST_LEAVE: begin
                    if (ev == OP_OCC_ON) begin
                        r = go_state(r, ST_OCC);
                    end else if (ev == OP_DELAY_TO) begin
                        if (r.bin) begin
                            r = raise_fault(r, FC_BIN);
                        end else if (r.guard) begin
                            r = go_state(r, idle_or_occ(r));
                        end else if (r.presence) begin
                            r = go_state(r, ST_OCC);
                        end else begin
                            r = go_state(r, ST_DELAY);
                        end
                    end else if (ev == OP_RESET) begin
                        r = reset_recover(r);
                    end else if (ev == OP_BINFULL) begin
                        r = raise_fault(r, FC_BIN);
                    end
                end
                ST_DELAY: begin
                    if (ev == OP_OCC_ON) begin
                        r = go_state(r, ST_OCC);
                    end else if (ev == OP_DELAY_TO || ev == OP_START) begin
                        r = try_clean(r);
                    end else if (ev == OP_RESET) begin
                        r = reset_recover(r);
                    end else if (ev == OP_BINFULL) begin
                        r = raise_fault(r, FC_BIN);
                    end
                end
                ST_CLEAN: begin
                    if (ev == OP_OCC_ON) begin
                        r = protect_stop(r);
                    end else if (ev == OP_BINFULL) begin
                        r = raise_fault(r, FC_BIN);
                    end else if (ev == OP_POS2 && r.phase == PH_P2) begin
                        r = start_leg(r, PH_P3);
                    end else if (ev == OP_POS3 && r.phase == PH_P3) begin
                        r = start_leg(r, PH_P1);
                    end else if ((ev == OP_POS1 && r.phase == PH_P1) || ev == OP_DONE
                                 || ev == OP_RESET) begin
                        r = go_state(r, ST_IDLE);
                    end
                end
                ST_SAFE: begin
                    if (ev == OP_PROT_OFF) begin
                        if (r.bin) begin
                            r = raise_fault(r, FC_BIN);
                        end else begin
                            r = recover_to(r, r.presence ? ST_OCC : ST_LEAVE);
                        end
                    end else if (ev == OP_RESET) begin
                        r = reset_recover(r);
                    end
                end
                ST_FAULT: begin
                    if (ev == OP_RESET) begin
                        r = reset_recover(r);
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/icsu_cfg.sv =====
// Configuration register file of the clean-cycle sequencer.
// Depends on icsu_pkg for the register indexes and the t_cfg type.
`default_nettype none

module icsu_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [2:0]                      i_cfg_idx,
    input  wire logic [icsu_pkg::CfgWidth-1:0]   i_cfg_data,
    output icsu_pkg::t_cfg                       o_cfg
);

    icsu_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leave_confirm_ticks <= 32'd2000;
            r_cfg.clean_delay_ticks   <= 32'd5000;
            r_cfg.phase_pos2_timeout  <= 32'd6000;
            r_cfg.phase_pos3_timeout  <= 32'd5000;
            r_cfg.phase_pos1_timeout  <= 32'd6000;
            r_cfg.total_clean_timeout <= 32'd20000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                icsu_pkg::CFG_LEAVE_CONFIRM: r_cfg.leave_confirm_ticks <= i_cfg_data;
                icsu_pkg::CFG_CLEAN_DELAY:   r_cfg.clean_delay_ticks   <= i_cfg_data;
                icsu_pkg::CFG_POS2_TIMEOUT:  r_cfg.phase_pos2_timeout  <= i_cfg_data;
                icsu_pkg::CFG_POS3_TIMEOUT:  r_cfg.phase_pos3_timeout  <= i_cfg_data;
                icsu_pkg::CFG_POS1_TIMEOUT:  r_cfg.phase_pos1_timeout  <= i_cfg_data;
                icsu_pkg::CFG_TOTAL_TIMEOUT: r_cfg.total_clean_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/icsu_step.sv =====
// Combinational next-state logic for one beat of the clean-cycle sequencer:
// counters, deadline checks and event handling. Depends on icsu_pkg.
`default_nettype none

module icsu_step #(
    parameter int unsigned TIMER_WIDTH = 32
) (
    input  wire icsu_pkg::t_in_item          i_item,
    input  wire icsu_pkg::t_cfg              i_cfg,
    input  wire icsu_pkg::t_ctx              i_ctx,
    input  wire logic [TIMER_WIDTH-1:0]      i_state_elapsed,
    input  wire logic [TIMER_WIDTH-1:0]      i_phase_elapsed,
    input  wire logic [TIMER_WIDTH-1:0]      i_cycle_elapsed,
    output icsu_pkg::t_ctx                   o_ctx,
    output logic [TIMER_WIDTH-1:0]           o_state_elapsed,
    output logic [TIMER_WIDTH-1:0]           o_phase_elapsed,
    output logic [TIMER_WIDTH-1:0]           o_cycle_elapsed
);

    localparam int unsigned CW = icsu_pkg::CfgWidth;

    logic            is_tick;
    logic [TIMER_WIDTH-1:0] se_b, ph_b, cy_b;
    logic [TIMER_WIDTH-1:0] se_t, ph_t, cy_t;
    logic [CW-1:0]   se_w, ph_w, cy_w;
    logic [CW-1:0]   leg_lim;
    icsu_pkg::t_ctx  base;
    icsu_pkg::t_ctx  c;

    // Saturating increments.
    assign se_b = (&i_state_elapsed) ? i_state_elapsed : i_state_elapsed + 1'b1;
    assign ph_b = (&i_phase_elapsed) ? i_phase_elapsed : i_phase_elapsed + 1'b1;
    assign cy_b = (&i_cycle_elapsed) ? i_cycle_elapsed : i_cycle_elapsed + 1'b1;

    assign se_w = CW'(se_b);
    assign ph_w = CW'(ph_b);
    assign cy_w = CW'(cy_b);

    assign is_tick = (i_item.op == icsu_pkg::OP_TICK);

    always_comb begin
        case (i_ctx.phase)
            icsu_pkg::PH_P2: leg_lim = i_cfg.phase_pos2_timeout;
            icsu_pkg::PH_P3: leg_lim = i_cfg.phase_pos3_timeout;
            icsu_pkg::PH_P1: leg_lim = i_cfg.phase_pos1_timeout;
            default:         leg_lim = '0;
        endcase
    end

    always_comb begin
        base = i_ctx;
        base.pulse = 1'b0;
        base.clr_state = 1'b0;
        base.clr_phase = 1'b0;
        base.clr_cycle = 1'b0;
        c = base;
        case (i_item.op)
            icsu_pkg::OP_TICK: begin
                if (base.mode == icsu_pkg::ST_CLEAN && base.guard) begin
                    c = icsu_pkg::dispatch(base, icsu_pkg::OP_PROT_ON);
                end else if (base.mode == icsu_pkg::ST_SAFE && !base.guard) begin
                    c = icsu_pkg::dispatch(base, icsu_pkg::OP_PROT_OFF);
                end else if (base.mode == icsu_pkg::ST_FAULT && base.fault == icsu_pkg::FC_BIN
                             && !base.bin) begin
                    c = icsu_pkg::recover_to(base, icsu_pkg::idle_or_occ(base));
                end else if (base.mode == icsu_pkg::ST_LEAVE) begin
                    if (se_w >= i_cfg.leave_confirm_ticks) begin
                        c = icsu_pkg::dispatch(base, icsu_pkg::OP_DELAY_TO);
                    end
                end else if (base.mode == icsu_pkg::ST_DELAY) begin
                    if (se_w >= i_cfg.clean_delay_ticks) begin
                        c = icsu_pkg::dispatch(base, icsu_pkg::OP_DELAY_TO);
                    end
                end else if (base.mode == icsu_pkg::ST_CLEAN) begin
                    if ((i_cfg.total_clean_timeout != '0 && cy_w >= i_cfg.total_clean_timeout)
                        || (leg_lim != '0 && ph_w >= leg_lim)) begin
                        c = icsu_pkg::dispatch(base, icsu_pkg::OP_STALL);
                    end
                end
            end
            icsu_pkg::OP_SYNC: begin
                c.presence = i_item.occupied_level;
                c.bin      = i_item.bin_full_level;
                c.guard    = i_item.protect_level;
            end
            icsu_pkg::OP_SPARE: ;
            default: c = icsu_pkg::dispatch(base, i_item.op);
        endcase
    end

    // A tick advances the counters first; any restart then wins.
    assign se_t = is_tick ? se_b : i_state_elapsed;
    assign ph_t = is_tick ? ph_b : i_phase_elapsed;
    assign cy_t = is_tick ? cy_b : i_cycle_elapsed;

    assign o_state_elapsed = c.clr_state ? '0 : se_t;
    assign o_phase_elapsed = c.clr_phase ? '0 : ph_t;
    assign o_cycle_elapsed = c.clr_cycle ? '0 : cy_t;
    assign o_ctx = c;

endmodule

`default_nettype wire

// ===== rtl/interlocked_clean_cycle_sequencer_unit.sv =====
// Top level of the interlocked clean-cycle sequencer: handshake stages,
// state registers and result register. Depends on icsu_pkg, icsu_cfg, icsu_step.
//
//   channel   | valid        | stall        | payload
//   ----------+--------------+--------------+-------------------------
//   item in   | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
//   result    | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
//   config    | i_cfg_we     | none         | i_cfg_idx, i_cfg_data
//
// Every beat goes through the input register and then the step logic into
// the result register. One beat per cycle is sustained unless the result
// side stalls, because the single-pass step logic is the only thing between
// the two registers. Reset is synchronous and active low and returns the
// configuration registers to their defaults and the sequencer to idle. A stall
// on the result side holds the result register, and the input register stalls
// only while both registers are full and the result is not taken.
`default_nettype none

module interlocked_clean_cycle_sequencer_unit #(
    parameter int unsigned TIMER_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire icsu_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output icsu_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [2:0]                      i_cfg_idx,
    input  wire logic [icsu_pkg::CfgWidth-1:0]   i_cfg_data
);

    icsu_pkg::t_cfg       cfg;

    // Input stage.
    logic                 r_in_vld;
    icsu_pkg::t_in_item   r_in;

    // Result stage.
    logic                 r_out_vld;
    icsu_pkg::t_out_item  r_out;
    icsu_pkg::t_out_item  n_out;

    // Sequencer state.
    icsu_pkg::t_ctx       r_ctx;
    icsu_pkg::t_ctx       n_ctx;
    logic [TIMER_WIDTH-1:0] r_state_elapsed, n_state_elapsed;
    logic [TIMER_WIDTH-1:0] r_phase_elapsed, n_phase_elapsed;
    logic [TIMER_WIDTH-1:0] r_cycle_elapsed, n_cycle_elapsed;

    logic                 advance;
    logic                 take_in;

    icsu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    icsu_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_item          (r_in),
        .i_cfg           (cfg),
        .i_ctx           (r_ctx),
        .i_state_elapsed (r_state_elapsed),
        .i_phase_elapsed (r_phase_elapsed),
        .i_cycle_elapsed (r_cycle_elapsed),
        .o_ctx           (n_ctx),
        .o_state_elapsed (n_state_elapsed),
        .o_phase_elapsed (n_phase_elapsed),
        .o_cycle_elapsed (n_cycle_elapsed)
    );

    // The beat in the input register is applied when the result register is
    // empty or is being emptied in this cycle.
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    always_comb begin
        n_out.cur_state     = n_ctx.mode;
        n_out.cur_phase     = n_ctx.phase;
        n_out.cur_fault     = n_ctx.fault;
        n_out.motor_cmd     = n_ctx.motor;
        n_out.fault_pulse   = n_ctx.pulse;
        n_out.bin_full_flag = n_ctx.bin;
        n_out.protect_flag  = n_ctx.guard;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ctx.mode      <= icsu_pkg::ST_IDLE;
            r_ctx.phase     <= icsu_pkg::PH_NONE;
            r_ctx.fault     <= icsu_pkg::FC_NONE;
            r_ctx.motor     <= icsu_pkg::MC_STOP;
            r_ctx.presence  <= 1'b0;
            r_ctx.bin       <= 1'b0;
            r_ctx.guard     <= 1'b0;
            r_ctx.pulse     <= 1'b0;
            r_ctx.clr_state <= 1'b0;
            r_ctx.clr_phase <= 1'b0;
            r_ctx.clr_cycle <= 1'b0;
            r_state_elapsed <= '0;
            r_phase_elapsed <= '0;
            r_cycle_elapsed <= '0;
        end else begin
            if (take_in) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld       <= 1'b1;
                r_ctx           <= n_ctx;
                r_state_elapsed <= n_state_elapsed;
                r_phase_elapsed <= n_phase_elapsed;
                r_cycle_elapsed <= n_cycle_elapsed;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/icsu_checker.sv =====
// Port-level checker for the clean-cycle sequencer, bound to its top level.
// Depends on icsu_pkg and the assertion macros header.
`default_nettype none
`include "interlocked_clean_cycle_sequencer_unit_defines.svh"

module icsu_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            o_in_stall,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    input  wire icsu_pkg::t_out_item             o_out_data
);

    logic in_clean;
    logic leg_active;

    assign in_clean   = (o_out_data.cur_state == icsu_pkg::ST_CLEAN);
    assign leg_active = (o_out_data.cur_phase != icsu_pkg::PH_NONE);

    // A stalled result holds its beat.
    `ICSU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // The input side stalls only behind a held result beat.
    `ICSU_ASSERT_IMP(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // A leg is in progress exactly while cleaning.
    `ICSU_ASSERT_IMP(a_leg_in_clean, o_out_valid, in_clean == leg_active)

    // The motor runs only during a leg, reverse only toward position three.
    `ICSU_ASSERT_IMP(a_motor_leg, o_out_valid,
        (o_out_data.motor_cmd == icsu_pkg::MC_REV) == (o_out_data.cur_phase == icsu_pkg::PH_P3)
        && ((o_out_data.motor_cmd == icsu_pkg::MC_STOP) == !leg_active))

    // A fault notification always leaves the sequencer in the fault state.
    `ICSU_ASSERT_IMP(a_pulse_fault, o_out_valid && o_out_data.fault_pulse,
        o_out_data.cur_state == icsu_pkg::ST_FAULT)

endmodule

bind interlocked_clean_cycle_sequencer_unit icsu_checker u_icsu_checker (.*);

`default_nettype wire

// ===== tb/tb_interlocked_clean_cycle_sequencer_unit.sv =====
// Self-checking testbench for the interlocked clean-cycle sequencer unit.
// Needs icsu_pkg and the top level; it predicts every result beat and compares it field by field.
`timescale 1ns / 1ps

module tb_interlocked_clean_cycle_sequencer_unit;

    import icsu_pkg::*;

    localparam int unsigned TIMER_BITS       = 32;
    localparam int unsigned CYCLE_LIMIT      = 300000;
    localparam int unsigned LONG_HOLD_CYCLES = 60;
    localparam int unsigned DRAIN_SLACK      = 4;
    localparam int unsigned MAX_REPORTS      = 30;

    // The opcode beyond the last event, and the two register indexes that
    // have no register behind them.
    localparam logic [3:0] OP_UNUSED   = 4'd15;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    // Clock, reset and every input of the block start at known values.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [2:0]           i_cfg_idx   = '0;
    logic [CfgWidth-1:0]  i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;

    interlocked_clean_cycle_sequencer_unit #(
        .TIMER_WIDTH(TIMER_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted sequencer state. It is advanced once per accepted input
    // beat, so the state seen by the stimulus generator is always the state
    // the block will be in once the beats already sent have been applied.
    // ------------------------------------------------------------------
    t_mode                 exp_mode;
    t_phase                exp_phase;
    t_fault                exp_fault;
    t_motor                exp_motor;
    logic                  exp_occupied;
    logic                  exp_bin;
    logic                  exp_guard;
    logic                  exp_pulse;
    logic [TIMER_BITS-1:0] age_state;
    logic [TIMER_BITS-1:0] age_leg;
    logic [TIMER_BITS-1:0] age_cycle;

    // Mirror of the configuration registers, reset values included.
    logic [CfgWidth-1:0] lim_leave = 32'd2000;
    logic [CfgWidth-1:0] lim_delay = 32'd5000;
    logic [CfgWidth-1:0] lim_pos2  = 32'd6000;
    logic [CfgWidth-1:0] lim_pos3  = 32'd5000;
    logic [CfgWidth-1:0] lim_pos1  = 32'd6000;
    logic [CfgWidth-1:0] lim_total = 32'd20000;

    // Expected status beats, oldest first.
    t_out_item   status_fifo[$];

    int unsigned err_count       = 0;
    int unsigned results_checked = 0;
    int unsigned settings_loaded = 0;
    int unsigned cycles_started  = 0;
    int unsigned cycle_count     = 0;

    // Idling controls for the sender (gaps) and the receiver (stalls, hold-off).
    logic gaps_on      = 1'b1;
    logic stall_on     = 1'b1;
    logic hold_off_req = 1'b0;

    function automatic logic [TIMER_BITS-1:0] sat_inc(logic [TIMER_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // A new leg restarts its timer and sets the motor direction: the legs to
    // positions two and one run forward, the leg to position three reverse.
    function automatic void leg_begin(t_phase p);
        exp_phase = p;
        age_leg   = '0;
        case (p)
            PH_P2, PH_P1: exp_motor = MC_FWD;
            PH_P3:        exp_motor = MC_REV;
            default:      exp_motor = MC_STOP;
        endcase
    endfunction

    // Entering the state already held is a no-op. Entering cleaning clears
    // the fault and starts the first leg; any other entry stops the motor.
    function automatic void enter_mode(t_mode s);
        if (exp_mode == s) return;
        exp_mode  = s;
        age_state = '0;
        if (s == ST_CLEAN) begin
            exp_fault = FC_NONE;
            age_cycle = '0;
            cycles_started++;
            leg_begin(PH_P2);
            return;
        end
        exp_phase = PH_NONE;
        exp_motor = MC_STOP;
        if (s == ST_IDLE || s == ST_OCC || s == ST_LEAVE || s == ST_DELAY) exp_fault = FC_NONE;
        if (s == ST_FAULT) exp_pulse = 1'b1;
    endfunction

    // A fault raised while already faulted only updates the code and pulses.
    function automatic void raise_alarm(t_fault code);
        exp_fault = code;
        if (exp_mode == ST_FAULT) begin
            exp_motor = MC_STOP;
            exp_pulse = 1'b1;
        end else begin
            enter_mode(ST_FAULT);
        end
    endfunction

    function automatic t_mode rest_mode();
        return exp_occupied ? ST_OCC : ST_IDLE;
    endfunction

    function automatic void recover_mode(t_mode s);
        exp_fault = FC_NONE;
        enter_mode(s);
    endfunction

    // Cleaning only starts with nobody present and both interlocks clear.
    function automatic void try_cycle();
        if (exp_occupied) enter_mode(rest_mode());
        else if (exp_bin) raise_alarm(FC_BIN);
        else if (exp_guard) enter_mode(rest_mode());
        else enter_mode(ST_CLEAN);
    endfunction

    function automatic void reset_request();
        if (exp_guard || exp_bin) return;
        recover_mode(rest_mode());
    endfunction

    function automatic void guard_trip();
        exp_fault = FC_PROTECT;
        enter_mode(ST_SAFE);
    endfunction

    // One event: the flag updates and the interlocks first, then the
    // reaction of the current state.
    function automatic void apply_event(logic [3:0] ev);
        case (ev)
            OP_OCC_ON:   exp_occupied = 1'b1;
            OP_OCC_OFF:  exp_occupied = 1'b0;
            OP_BINFULL:  exp_bin = 1'b1;
            OP_PROT_ON: begin
                exp_guard = 1'b1;
                if (exp_mode == ST_CLEAN) guard_trip();
                return;
            end
            OP_PROT_OFF: exp_guard = 1'b0;
            OP_STALL: begin
                raise_alarm(FC_TIMEOUT);
                return;
            end
            default: ;
        endcase

        case (exp_mode)
            ST_IDLE, ST_OCC: begin
                if (exp_mode == ST_IDLE && ev == OP_OCC_ON) enter_mode(ST_OCC);
                else if (exp_mode == ST_OCC && ev == OP_OCC_OFF) enter_mode(ST_LEAVE);
                else if (ev == OP_START) try_cycle();
                else if (ev == OP_BINFULL) raise_alarm(FC_BIN);
            end
            ST_LEAVE: begin
                if (ev == OP_OCC_ON) begin
                    enter_mode(ST_OCC);
                end else if (ev == OP_DELAY_TO) begin
                    if (exp_bin) raise_alarm(FC_BIN);
                    else if (exp_guard) enter_mode(rest_mode());
                    else if (exp_occupied) enter_mode(ST_OCC);
                    else enter_mode(ST_DELAY);
                end else if (ev == OP_RESET) begin
                    reset_request();
                end else if (ev == OP_BINFULL) begin
                    raise_alarm(FC_BIN);
                end
            end
            ST_DELAY: begin
                if (ev == OP_OCC_ON) enter_mode(ST_OCC);
                else if (ev == OP_DELAY_TO || ev == OP_START) try_cycle();
                else if (ev == OP_RESET) reset_request();
                else if (ev == OP_BINFULL) raise_alarm(FC_BIN);
            end
            ST_CLEAN: begin
                if (ev == OP_OCC_ON) guard_trip();
                else if (ev == OP_BINFULL) raise_alarm(FC_BIN);
                else if (ev == OP_POS2 && exp_phase == PH_P2) leg_begin(PH_P3);
                else if (ev == OP_POS3 && exp_phase == PH_P3) leg_begin(PH_P1);
                else if ((ev == OP_POS1 && exp_phase == PH_P1) || ev == OP_DONE
                         || ev == OP_RESET) enter_mode(ST_IDLE);
            end
            ST_SAFE: begin
                if (ev == OP_PROT_OFF) begin
                    if (exp_bin) raise_alarm(FC_BIN);
                    else recover_mode(exp_occupied ? ST_OCC : ST_LEAVE);
                end else if (ev == OP_RESET) begin
                    reset_request();
                end
            end
            ST_FAULT: begin
                if (ev == OP_RESET) reset_request();
            end
            default: ;
        endcase
    endfunction

    // A tick ages all three timers, then handles at most one of the
    // interlock recoveries, the deadlines and the timeouts.
    function automatic void apply_tick();
        logic [CfgWidth-1:0] leg_lim;
        age_state = sat_inc(age_state);
        age_leg   = sat_inc(age_leg);
        age_cycle = sat_inc(age_cycle);

        if (exp_mode == ST_CLEAN && exp_guard) begin
            apply_event(OP_PROT_ON);
            return;
        end
        if (exp_mode == ST_SAFE && !exp_guard) begin
            apply_event(OP_PROT_OFF);
            return;
        end
        if (exp_mode == ST_FAULT && exp_fault == FC_BIN && !exp_bin) begin
            recover_mode(rest_mode());
            return;
        end

        case (exp_phase)
            PH_P2:   leg_lim = lim_pos2;
            PH_P3:   leg_lim = lim_pos3;
            PH_P1:   leg_lim = lim_pos1;
            default: leg_lim = '0;
        endcase

        if (exp_mode == ST_LEAVE) begin
            if (age_state >= lim_leave) apply_event(OP_DELAY_TO);
        end else if (exp_mode == ST_DELAY) begin
            if (age_state >= lim_delay) apply_event(OP_DELAY_TO);
        end else if (exp_mode == ST_CLEAN) begin
            // A zero limit disables its timeout; the whole-cycle limit wins.
            if (lim_total != 0 && age_cycle >= lim_total) apply_event(OP_STALL);
            else if (leg_lim != 0 && age_leg >= leg_lim) apply_event(OP_STALL);
        end
    endfunction

    // Applies one input beat and returns the status beat it produces.
    function automatic t_out_item predict_status(t_in_item beat);
        t_out_item s;
        exp_pulse = 1'b0;
        if (beat.op == OP_TICK) begin
            apply_tick();
        end else if (beat.op == OP_SYNC) begin
            exp_occupied = beat.occupied_level;
            exp_bin      = beat.bin_full_level;
            exp_guard    = beat.protect_level;
        end else if (beat.op <= OP_DONE) begin
            apply_event(beat.op);
        end
        s.cur_state     = exp_mode;
        s.cur_phase     = exp_phase;
        s.cur_fault     = exp_fault;
        s.motor_cmd     = exp_motor;
        s.fault_pulse   = exp_pulse;
        s.bin_full_flag = exp_bin;
        s.protect_flag  = exp_guard;
        return s;
    endfunction

    function automatic void clear_prediction();
        exp_mode     = ST_IDLE;
        exp_phase    = PH_NONE;
        exp_fault    = FC_NONE;
        exp_motor    = MC_STOP;
        exp_occupied = 1'b0;
        exp_bin      = 1'b0;
        exp_guard    = 1'b0;
        exp_pulse    = 1'b0;
        age_state    = '0;
        age_leg      = '0;
        age_cycle    = '0;
    endfunction

    function automatic t_in_item mk_beat(logic [3:0] op, logic occ, logic bin, logic prot);
        t_in_item b;
        b.op             = op;
        b.occupied_level = occ;
        b.bin_full_level = bin;
        b.protect_level  = prot;
        return b;
    endfunction

    // Picks the next random beat. About a fifth is pure noise; the rest
    // steers the sequencer through well-formed cleaning cycles, clears the
    // interlocks when they block progress, and now and then breaks a cycle
    // with a protect, a bin-full, a stall or a premature done.
    function automatic t_in_item pick_beat();
        t_in_item    b;
        logic [6:0]  raw;
        int unsigned r;
        raw = 7'($urandom);
        b   = raw;
        if ($urandom_range(0, 99) < 18) return b;
        r = $urandom_range(0, 99);
        case (exp_mode)
            ST_IDLE: begin
                if ((exp_bin || exp_guard) && r < 40) b.op = OP_SYNC;
                else if (r < 55) b.op = OP_OCC_ON;
                else if (r < 75) b.op = OP_START;
                else if (r < 94) b.op = OP_TICK;
                else b.op = OP_BINFULL;
            end
            ST_OCC: begin
                if ((exp_bin || exp_guard) && r < 30) b.op = OP_SYNC;
                else if (r < 70) b.op = OP_OCC_OFF;
                else if (r < 85) b.op = OP_TICK;
                else if (r < 95) b.op = OP_START;
                else b.op = OP_BINFULL;
            end
            ST_LEAVE: begin
                if ((exp_bin || exp_guard) && r < 25) b.op = OP_SYNC;
                else if (r < 75) b.op = OP_TICK;
                else if (r < 85) b.op = OP_DELAY_TO;
                else if (r < 92) b.op = OP_OCC_ON;
                else if (r < 97) b.op = OP_RESET;
                else b.op = OP_BINFULL;
            end
            ST_DELAY: begin
                if ((exp_bin || exp_guard) && r < 25) b.op = OP_SYNC;
                else if (r < 70) b.op = OP_TICK;
                else if (r < 82) b.op = OP_START;
                else if (r < 90) b.op = OP_DELAY_TO;
                else if (r < 95) b.op = OP_OCC_ON;
                else if (r < 98) b.op = OP_RESET;
                else b.op = OP_BINFULL;
            end
            ST_CLEAN: begin
                if (r < 50) begin
                    case (exp_phase)
                        PH_P2:   b.op = OP_POS2;
                        PH_P3:   b.op = OP_POS3;
                        PH_P1:   b.op = OP_POS1;
                        default: b.op = OP_TICK;
                    endcase
                end
                else if (r < 85) b.op = OP_TICK;
                else if (r < 88) b.op = OP_DONE;
                else if (r < 90) b.op = OP_RESET;
                else if (r < 93) b.op = OP_PROT_ON;
                else if (r < 95) b.op = OP_OCC_ON;
                else if (r < 97) b.op = OP_BINFULL;
                else b.op = OP_STALL;
            end
            ST_SAFE: begin
                if (exp_guard && r < 50) b.op = OP_SYNC;
                else if (r < 75) b.op = OP_TICK;
                else if (r < 90) b.op = OP_PROT_OFF;
                else b.op = OP_RESET;
            end
            ST_FAULT: begin
                if ((exp_bin || exp_guard) && r < 50) b.op = OP_SYNC;
                else if (r < 80) b.op = OP_RESET;
                else b.op = OP_TICK;
            end
            default: b.op = OP_TICK;
        endcase
        // A steered sync keeps the presence level and mostly clears both
        // interlocks.
        if (b.op == OP_SYNC) begin
            b.occupied_level = exp_occupied;
            b.bin_full_level = ($urandom_range(0, 15) == 0);
            b.protect_level  = ($urandom_range(0, 15) == 0);
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Entered and left at a falling edge. The valid stays high
    // after an accepted beat, so back-to-back beats never drop it; any task
    // that does not send next lowers it at that same falling edge.
    // ------------------------------------------------------------------
    task automatic send_beat(input t_in_item beat);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        status_fifo.push_back(predict_status(beat));
        @(negedge i_clk);
    endtask

    // Stops offering beats and waits until every expected status beat has
    // come back, plus the DRAIN_SLACK wait for the two pipeline registers.
    task automatic wait_status_drained();
        i_in_valid <= 1'b0;
        while (status_fifo.size() != 0) @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    // One register write per cycle; the write enable is left high so that
    // back-to-back writes never lower and raise it in the same step.
    task automatic write_reg(input logic [2:0] idx, input logic [CfgWidth-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_LEAVE_CONFIRM: lim_leave = value;
            CFG_CLEAN_DELAY:   lim_delay = value;
            CFG_POS2_TIMEOUT:  lim_pos2  = value;
            CFG_POS3_TIMEOUT:  lim_pos3  = value;
            CFG_POS1_TIMEOUT:  lim_pos1  = value;
            CFG_TOTAL_TIMEOUT: lim_total = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Loads all six limits, plus junk to the two unused indexes, which the
    // block has to ignore. Only called while no beats are in flight.
    task automatic load_settings(input logic [CfgWidth-1:0] leave_t, delay_t,
                                 pos2_t, pos3_t, pos1_t, total_t);
        write_reg(CFG_LEAVE_CONFIRM, leave_t);
        write_reg(CFG_CLEAN_DELAY, delay_t);
        write_reg(CFG_POS2_TIMEOUT, pos2_t);
        write_reg(CFG_POS3_TIMEOUT, pos3_t);
        write_reg(CFG_POS1_TIMEOUT, pos1_t);
        write_reg(CFG_TOTAL_TIMEOUT, total_t);
        write_reg(CFG_SPARE_6, $urandom);
        write_reg(CFG_SPARE_7, $urandom);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic load_small_settings();
        load_settings($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(1, 10),
                      $urandom_range(1, 10), $urandom_range(1, 10),
                      ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(12, 40)));
    endtask

    task automatic send_random_beats(input int unsigned count);
        repeat (count) send_beat(pick_beat());
    endtask

    // ------------------------------------------------------------------
    // Receiver. Stalls come in random bursts of random length; a hold-off
    // request replaces the next burst with one long stall.
    // ------------------------------------------------------------------
    initial begin : result_stall_driver
        int unsigned burst;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 10);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_REPORTS) begin
            $display("MISMATCH at status beat %0d, %s: got %0d, expected %0d",
                     results_checked, what, got, want);
        end
        err_count++;
    endtask

    // Every status beat taken at a rising edge is checked against the
    // oldest prediction.
    t_out_item want_status;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_fifo.size() == 0) begin
                report_mismatch("beat with nothing expected", int'(o_out_data), -1);
            end else begin
                want_status = status_fifo.pop_front();
                if (o_out_data.cur_state !== want_status.cur_state)
                    report_mismatch("cur_state", o_out_data.cur_state, want_status.cur_state);
                if (o_out_data.cur_phase !== want_status.cur_phase)
                    report_mismatch("cur_phase", o_out_data.cur_phase, want_status.cur_phase);
                if (o_out_data.cur_fault !== want_status.cur_fault)
                    report_mismatch("cur_fault", o_out_data.cur_fault, want_status.cur_fault);
                if (o_out_data.motor_cmd !== want_status.motor_cmd)
                    report_mismatch("motor_cmd", o_out_data.motor_cmd, want_status.motor_cmd);
                if (o_out_data.fault_pulse !== want_status.fault_pulse)
                    report_mismatch("fault_pulse", o_out_data.fault_pulse,
                                    want_status.fault_pulse);
                if (o_out_data.bin_full_flag !== want_status.bin_full_flag)
                    report_mismatch("bin_full_flag", o_out_data.bin_full_flag,
                                    want_status.bin_full_flag);
                if (o_out_data.protect_flag !== want_status.protect_flag)
                    report_mismatch("protect_flag", o_out_data.protect_flag,
                                    want_status.protect_flag);
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With the reset limits no deadline can be reached in a few beats; this
    // checks the reset state, the unused opcode and the sync levels.
    task automatic test_reset_defaults();
        send_beat(mk_beat(OP_UNUSED, 1'b1, 1'b1, 1'b1));
        send_beat(mk_beat(OP_SYNC, 1'b1, 1'b1, 1'b1));
        send_beat(mk_beat(OP_SYNC, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_OCC_ON, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_OCC_OFF, 1'b1, 1'b1, 1'b1));
        send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 1'b0));
        wait_status_drained();
    endtask

    // Zero confirm and delay limits fire on the first tick, and the legs
    // time out after two ticks. The walk visits every opcode but the spare
    // one: a full cycle, an out-of-order position, a same-state entry, a leg
    // timeout, a fault raised while faulted, a blocked and an allowed reset,
    // a protect stop and its recovery, and the bin-full auto-recovery.
    task automatic test_directed_walkthrough();
        load_settings(32'd0, 32'd0, 32'd2, 32'd2, 32'd2, 32'd0);
        send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_POS3, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_POS2, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_POS3, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_POS1, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_OCC_ON, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_START, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_OCC_OFF, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_DELAY_TO, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_START, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_STALL, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_BINFULL, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_RESET, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_SYNC, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_RESET, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_START, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_PROT_ON, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_PROT_OFF, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_SYNC, 1'b0, 1'b1, 1'b1));
        send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_SYNC, 1'b0, 1'b0, 1'b1));
        send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_START, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_PROT_OFF, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_START, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(OP_DONE, 1'b0, 1'b0, 1'b0));
        wait_status_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats without gaps, so both registers fill and the input
    // side has to stall.
    task automatic test_backpressure();
        logic saved_gaps;
        saved_gaps   = gaps_on;
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        send_random_beats(24);
        gaps_on = saved_gaps;
        wait_status_drained();
    endtask

    // The sender stops in the middle of the traffic until every expected
    // beat has come back, then carries on from the same sequencer state.
    task automatic test_sender_pause();
        load_small_settings();
        send_random_beats(20);
        wait_status_drained();
        send_random_beats(20);
        wait_status_drained();
    endtask

    // Random traffic under several limit settings: small limits, all zeros
    // (deadlines on the first tick, timeouts off), all ones (nothing ever
    // expires), a tight whole-cycle limit with the leg limits off, and
    // wide random limits.
    task automatic test_random_settings();
        load_small_settings();
        send_random_beats(450);
        wait_status_drained();

        load_settings('0, '0, '0, '0, '0, '0);
        send_random_beats(250);
        wait_status_drained();

        load_settings('1, '1, '1, '1, '1, '1);
        send_random_beats(250);
        wait_status_drained();

        load_settings($urandom_range(0, 3), $urandom_range(0, 3), '0, '0, '0,
                      $urandom_range(4, 12));
        send_random_beats(250);
        wait_status_drained();

        load_settings($urandom_range(0, 3), $urandom_range(0, 3), $urandom, $urandom,
                      $urandom, $urandom);
        send_random_beats(250);
        wait_status_drained();
    endtask

    // The last part of the run goes at full rate with no idling on either
    // side.
    task automatic test_quiet_tail();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        load_small_settings();
        send_random_beats(200);
        wait_status_drained();
    endtask

    initial begin
        clear_prediction();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed_walkthrough();
        test_backpressure();
        test_sender_pause();
        test_random_settings();
        test_quiet_tail();

        $display("Summary: %0d status beats checked under %0d limit settings, %0d cleaning cycles",
                 results_checked, settings_loaded, cycles_started);
        $display("Summary: every opcode, interlock recoveries, zero and all-ones limits, stalls");
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
